>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the interval set checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define ISI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("interval set check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define ISI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("interval set check failed");

`endif

>>> rtl/core/isi_pkg.sv
// ----------------------------------------------------------------------------
// Interval set package
// Types, codes and sizes shared by the interval set cells and control.
// ----------------------------------------------------------------------------
`default_nettype none

package isi_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int RIDX_W   = 4;
  localparam int SCNT_W   = 5;

  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_READ   = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_MERGED   = 3'd1,
    ST_COVERED  = 3'd2,
    ST_FULL     = 3'd3,
    ST_READ     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_APPLY,
    S_COLLAPSE
  } state_e;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_LOAD,
    OP_SHIFT_UP,
    OP_SHIFT_DN,
    OP_MERGE,
    OP_ABSORB
  } cell_op_e;

  typedef struct packed {
    logic signed [VAL_W-1:0] first_val;
    logic signed [VAL_W-1:0] last_val;
  } range_t;

  typedef struct packed {
    logic covered;
    logic touch;
    logic below;
  } cell_flags_t;

  typedef struct packed {
    func_e                   func;
    logic signed [VAL_W-1:0] range_first;
    logic signed [VAL_W-1:0] range_last;
    logic [RIDX_W-1:0]       read_index;
  } req_t;

  typedef struct packed {
    status_e                 status;
    logic signed [VAL_W-1:0] entry_first;
    logic signed [VAL_W-1:0] entry_last;
    logic                    entry_valid;
    logic [SCNT_W-1:0]       stored_count;
  } rsp_t;

endpackage

`default_nettype wire

>>> rtl/core/interval_set_merge_insert.sv
// ----------------------------------------------------------------------------
// Interval set merge insert: a row of range cells with a merging insert.
// Timing: the accept edge captures the cell flags and enters S_APPLY; a merge
// that removes k extra entries then takes k S_COLLAPSE steps, one per shift
// of the cell row. The result beat is registered on leaving the last state.
// A new item is taken only while idle, not while one is in progress. Reset clears
// the count and the control only; stored ranges are unread until written.
// ----------------------------------------------------------------------------
`default_nettype none

module interval_set_merge_insert (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  input  wire isi_pkg::req_t req_i,
  output logic               busy,
  output logic               strobe_o,
  output isi_pkg::rsp_t      rsp_o
);

  localparam int CAP = isi_pkg::CAPACITY;

  // An inverted range is swapped before anything compares against it, so the
  // cells always see first <= last.
  isi_pkg::range_t      key_in, key;
  logic                 swap;
  isi_pkg::range_t      entries [CAP];
  isi_pkg::cell_flags_t flags   [CAP];
  isi_pkg::cell_op_e    ops     [CAP];

  assign swap             = req_i.range_last < req_i.range_first;
  assign key_in.first_val = swap ? req_i.range_last  : req_i.range_first;
  assign key_in.last_val  = swap ? req_i.range_first : req_i.range_last;

  // Each cell holds one range in sorted order. On the accept edge every
  // cell's cover, touch and below flags are captured at once; in the cycles
  // after, cells move data only to or from their direct neighbors. Cells at
  // the ends of the row see themselves as their missing neighbor; what they
  // take from there lies beyond the count and is never read.
  for (genvar i = 0; i < CAP; i++) begin : g_cell
    isi_pkg::range_t prev_ent, next_ent;

    if (i == 0) begin : g_first
      assign prev_ent = entries[i];
    end else begin : g_mid_lo
      assign prev_ent = entries[i-1];
    end

    if (i == CAP - 1) begin : g_last
      assign next_ent = entries[i];
    end else begin : g_mid_hi
      assign next_ent = entries[i+1];
    end

    isi_cell u_cell (
      .clk_i   (clk_i),
      .op_i    (ops[i]),
      .key_i   (key),
      .prev_i  (prev_ent),
      .next_i  (next_ent),
      .entry_o (entries[i]),
      .flags_o (flags[i])
    );
  end

  // The control decides per item: read, covered, merge (head update then one
  // collapse step per extra merged entry), table full, or sorted insert.
  isi_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .req_i     (req_i),
    .key_in_i  (key_in),
    .entries_i (entries),
    .flags_i   (flags),
    .busy_o    (busy),
    .key_o     (key),
    .ops_o     (ops),
    .strobe_o  (strobe_o),
    .rsp_o     (rsp_o)
  );

endmodule

`default_nettype wire

>>> rtl/core/isi_cell.sv
// ----------------------------------------------------------------------------
// Interval set cell
// Holds one stored range, compares it with the probe range and takes a new
// value from itself, its neighbors or the probe as the control orders.
// ----------------------------------------------------------------------------
`default_nettype none

module isi_cell (
  input  wire logic                clk_i,
  input  wire isi_pkg::cell_op_e   op_i,
  input  wire isi_pkg::range_t     key_i,
  input  wire isi_pkg::range_t     prev_i,
  input  wire isi_pkg::range_t     next_i,
  output isi_pkg::range_t          entry_o,
  output isi_pkg::cell_flags_t     flags_o
);

  localparam logic signed [isi_pkg::VAL_W:0] ONE_X = 1;

  isi_pkg::range_t ent_q, ent_d;
  logic signed [isi_pkg::VAL_W:0] s_x, e_x, f_x, l_x;

  // Adjacency needs one bit of headroom, so the touch test works at 33 bits.
  assign s_x = {ent_q.first_val[isi_pkg::VAL_W-1], ent_q.first_val};
  assign e_x = {ent_q.last_val[isi_pkg::VAL_W-1], ent_q.last_val};
  assign f_x = {key_i.first_val[isi_pkg::VAL_W-1], key_i.first_val};
  assign l_x = {key_i.last_val[isi_pkg::VAL_W-1], key_i.last_val};

  assign flags_o.covered = (ent_q.first_val <= key_i.first_val) &&
                           (key_i.last_val <= ent_q.last_val);
  assign flags_o.touch   = (s_x <= l_x + ONE_X) && (e_x + ONE_X >= f_x);
  assign flags_o.below   = ent_q.last_val < key_i.first_val;

  always_comb begin
    ent_d = ent_q;
    case (op_i)
      isi_pkg::OP_HOLD:     ent_d = ent_q;
      isi_pkg::OP_LOAD:     ent_d = key_i;
      isi_pkg::OP_SHIFT_UP: ent_d = prev_i;
      isi_pkg::OP_SHIFT_DN: ent_d = next_i;
      isi_pkg::OP_MERGE: begin
        if (key_i.first_val < ent_q.first_val) ent_d.first_val = key_i.first_val;
        if (key_i.last_val > ent_q.last_val)   ent_d.last_val  = key_i.last_val;
      end
      isi_pkg::OP_ABSORB: begin
        if (next_i.last_val > ent_q.last_val)  ent_d.last_val  = next_i.last_val;
      end
      default:              ent_d = ent_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign entry_o = ent_q;

endmodule

`default_nettype wire

>>> rtl/core/isi_ctrl.sv
// ----------------------------------------------------------------------------
// Interval set control
// Sequences one item: latches the cell flags, orders the cell row, keeps
// the range count and forms the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module isi_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire isi_pkg::req_t        req_i,
  input  wire isi_pkg::range_t      key_in_i,
  input  wire isi_pkg::range_t      entries_i [isi_pkg::CAPACITY],
  input  wire isi_pkg::cell_flags_t flags_i [isi_pkg::CAPACITY],
  output logic                      busy_o,
  output isi_pkg::range_t           key_o,
  output isi_pkg::cell_op_e         ops_o [isi_pkg::CAPACITY],
  output logic                      strobe_o,
  output isi_pkg::rsp_t             rsp_o
);

  localparam int CAP = isi_pkg::CAPACITY;

  isi_pkg::state_e              state_q, state_d;
  isi_pkg::func_e               func_q;
  logic [isi_pkg::RIDX_W-1:0]   idx_q;
  isi_pkg::range_t              rng_q;
  logic [CAP-1:0]               valid, mrg_now, below_now, cov_now;
  logic [CAP-1:0]               mrg_q, below_q, below_prev;
  logic                         cov_q, any_q, accept;
  logic [isi_pkg::IDX_W-1:0]    lo_q, lo_d;
  logic [isi_pkg::CNT_W-1:0]    gone_q, gone_now, count_q, count_d;
  isi_pkg::rsp_t                rsp_q, rsp_d;
  logic                         strobe_q, strobe_d;
  isi_pkg::range_t              rd_entry;
  logic                         rd_ok;
  int                           ones;

  assign accept = start_i && (state_q == isi_pkg::S_IDLE);
  assign busy_o = (state_q != isi_pkg::S_IDLE);
  assign key_o  = (state_q == isi_pkg::S_IDLE) ? key_in_i : rng_q;

  always_comb begin
    for (int i = 0; i < CAP; i++) begin
      valid[i]     = isi_pkg::CNT_W'(i) < count_q;
      mrg_now[i]   = flags_i[i].touch && valid[i];
      below_now[i] = flags_i[i].below && valid[i];
      cov_now[i]   = flags_i[i].covered && valid[i];
    end
  end

  // Lowest merging cell; merging cells always form one contiguous run.
  always_comb begin
    lo_d = '0;
    for (int i = CAP - 1; i >= 0; i--) begin
      if (mrg_now[i]) lo_d = isi_pkg::IDX_W'(i);
    end
  end

  assign ones     = $countones(mrg_now);
  assign gone_now = (ones == 0) ? '0 : isi_pkg::CNT_W'(ones - 1);
  assign any_q    = |mrg_q;
  assign below_prev = {below_q[CAP-2:0], 1'b1};

  always_comb begin
    rd_entry = '0;
    for (int i = 0; i < CAP; i++) begin
      if (int'(idx_q) == i) rd_entry = entries_i[i];
    end
    rd_ok = int'(idx_q) < int'(count_q);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      isi_pkg::S_IDLE: begin
        if (accept) state_d = isi_pkg::S_APPLY;
      end
      isi_pkg::S_APPLY: begin
        if ((func_q == isi_pkg::FUNC_INSERT) && !cov_q && any_q && (gone_q != '0)) begin
          state_d = isi_pkg::S_COLLAPSE;
        end else begin
          state_d = isi_pkg::S_IDLE;
        end
      end
      isi_pkg::S_COLLAPSE: begin
        if (gone_q == isi_pkg::CNT_W'(1)) state_d = isi_pkg::S_IDLE;
      end
      default: state_d = isi_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    for (int i = 0; i < CAP; i++) ops_o[i] = isi_pkg::OP_HOLD;
    count_d  = count_q;
    strobe_d = 1'b0;
    rsp_d    = '0;
    case (state_q)
      isi_pkg::S_IDLE: begin
        strobe_d = 1'b0;
      end
      isi_pkg::S_APPLY: begin
        if (func_q == isi_pkg::FUNC_READ) begin
          strobe_d     = 1'b1;
          rsp_d.status = isi_pkg::ST_READ;
          if (rd_ok) begin
            rsp_d.entry_first = rd_entry.first_val;
            rsp_d.entry_last  = rd_entry.last_val;
            rsp_d.entry_valid = 1'b1;
          end
        end else if (cov_q) begin
          strobe_d     = 1'b1;
          rsp_d.status = isi_pkg::ST_COVERED;
        end else if (any_q) begin
          ops_o[lo_q]  = isi_pkg::OP_MERGE;
          strobe_d     = (gone_q == '0);
          rsp_d.status = isi_pkg::ST_MERGED;
        end else if (count_q >= isi_pkg::CNT_W'(CAP)) begin
          strobe_d     = 1'b1;
          rsp_d.status = isi_pkg::ST_FULL;
        end else begin
          // The first cell not below the new range takes it, the rest move up.
          for (int i = 0; i < CAP; i++) begin
            if (below_q[i]) begin
              ops_o[i] = isi_pkg::OP_HOLD;
            end else if (below_prev[i]) begin
              ops_o[i] = isi_pkg::OP_LOAD;
            end else begin
              ops_o[i] = isi_pkg::OP_SHIFT_UP;
            end
          end
          count_d      = count_q + 1'b1;
          strobe_d     = 1'b1;
          rsp_d.status = isi_pkg::ST_INSERTED;
        end
      end
      isi_pkg::S_COLLAPSE: begin
        // The head absorbs its successor's end and the tail closes the gap.
        for (int i = 0; i < CAP; i++) begin
          if (isi_pkg::IDX_W'(i) == lo_q) begin
            ops_o[i] = isi_pkg::OP_ABSORB;
          end else if (isi_pkg::IDX_W'(i) > lo_q) begin
            ops_o[i] = isi_pkg::OP_SHIFT_DN;
          end
        end
        count_d      = count_q - 1'b1;
        strobe_d     = (gone_q == isi_pkg::CNT_W'(1));
        rsp_d.status = isi_pkg::ST_MERGED;
      end
      default: strobe_d = 1'b0;
    endcase
    rsp_d.stored_count = isi_pkg::SCNT_W'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= isi_pkg::S_IDLE;
      count_q  <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q  <= req_i.func;
      idx_q   <= req_i.read_index;
      rng_q   <= key_in_i;
      mrg_q   <= mrg_now;
      below_q <= below_now;
      cov_q   <= |cov_now;
      lo_q    <= lo_d;
      gone_q  <= gone_now;
    end else if (state_q == isi_pkg::S_COLLAPSE) begin
      gone_q  <= gone_q - 1'b1;
    end
    rsp_q <= rsp_d;
  end

  assign strobe_o = strobe_q;
  assign rsp_o    = rsp_q;

endmodule

`default_nettype wire

>>> rtl/core/isi_checker.sv
// ----------------------------------------------------------------------------
// Interval set checker
// Port-level checks on the command handshake and the result beat timing.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module isi_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          start,
  input wire logic          busy,
  input wire logic          strobe_o,
  input wire isi_pkg::rsp_t rsp_o
);

  logic rsp_non_read;

  assign rsp_non_read = rsp_o.status != isi_pkg::ST_READ;

  // An accepted command always occupies the block for the next cycle.
  `ISI_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy)

  // A result beat only appears once the block has gone idle again.
  `ISI_ASSERT_NOW(a_beat_idle, clk_i, rst_ni, strobe_o, !busy)

  // Two result beats never come back to back.
  `ISI_ASSERT_NEXT(a_beat_gap, clk_i, rst_ni, strobe_o, !strobe_o)

  // Only a read beat can report a valid entry.
  `ISI_ASSERT_NOW(a_entry_read, clk_i, rst_ni, strobe_o && rsp_non_read, !rsp_o.entry_valid)

endmodule

bind interval_set_merge_insert isi_checker u_checker (.*);

`default_nettype wire
